>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define DMN_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define DMN_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/dmn_pkg.sv
`default_nettype none

package dmn_pkg;

  localparam int unsigned MaxNodes     = 16;
  localparam int unsigned NodeLim      = (MaxNodes < 16) ? MaxNodes : 16;
  localparam int unsigned ClockBitsDef = 32;

  localparam int unsigned NodeIdW  = 4;
  localparam int unsigned NodeCntW = 5;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StampW   = 32;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  localparam int unsigned FifoDepth = 15;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_LREQ = 2'd0,
    CMD_LREL = 2'd1,
    CMD_RREQ = 2'd2,
    CMD_RACK = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_REQ   = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_GRANT = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_ID    = 1'b0,
    CFG_NODE_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [NodeIdW-1:0] src;
  } item_hdr_t;

  typedef struct packed {
    logic [NodeIdW-1:0] node_id;
    logic [NodeIdW-1:0] want;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/dmn_ifs.sv
`default_nettype none

interface dmn_in_if;
  logic                         valid;
  logic                         ready;
  logic [dmn_pkg::CmdW-1:0]     command;
  logic [dmn_pkg::NodeIdW-1:0]  source;
  logic [dmn_pkg::StampW-1:0]   stamp_in;

  modport src (output valid, command, source, stamp_in, input ready);
  modport snk (input valid, command, source, stamp_in, output ready);
endinterface

interface dmn_out_if;
  logic                         valid;
  logic                         ready;
  logic [dmn_pkg::KindW-1:0]    kind;
  logic [dmn_pkg::NodeIdW-1:0]  dest;
  logic [dmn_pkg::StampW-1:0]   stamp_out;
  logic                         last;

  modport src (output valid, kind, dest, stamp_out, last, input ready);
  modport snk (input valid, kind, dest, stamp_out, last, output ready);
endinterface

`default_nettype wire

>>> rtl/distributed_mutex_node_core.sv
// Ricart-Agrawala mutual-exclusion node with a saturating Lamport clock. Input beats are
// decoded and queued by a front end (two entries); a back-end sequencer executes them one
// at a time and drives a registered result beat, so a stalled result never blocks the
// queue from filling. A local request scans the ids in the REQ broadcast, a local release
// sends an ACK to each deferred node, and a received REQ or ACK passes through a clock
// sync state before it executes; the back end's single result register sends at most one
// beat per cycle, and stalls while the sink is not ready. Write node_id and node_count only while idle.
`default_nettype none

module distributed_mutex_node_core #(
  parameter int unsigned ClockBits = dmn_pkg::ClockBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dmn_pkg::CfgDataW-1:0]  cfg_wdata_i,
  dmn_in_if.snk                         in_ch,
  dmn_out_if.src                        out_ch
);

  logic [dmn_pkg::NodeIdW-1:0]   node_id_q;
  logic [dmn_pkg::NodeCntW-1:0]  node_count_q;
  dmn_pkg::cfg_t                 cfg;
  logic                          q_valid, q_pop;
  dmn_pkg::item_hdr_t            q_hdr;
  logic [ClockBits-1:0]          q_stamp;

  function automatic logic [dmn_pkg::NodeIdW-1:0] peers(logic [dmn_pkg::NodeCntW-1:0] n);
    logic [dmn_pkg::NodeCntW-1:0] e;
    e = n;
    if (e == '0) begin
      e = dmn_pkg::NodeCntW'(1);
    end
    if (e > dmn_pkg::NodeCntW'(dmn_pkg::NodeLim)) begin
      e = dmn_pkg::NodeCntW'(dmn_pkg::NodeLim);
    end
    return dmn_pkg::NodeIdW'(e - 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      node_count_q <= dmn_pkg::NodeCntW'(2);
    end else if (cfg_we_i) begin
      unique case (dmn_pkg::cfg_idx_e'(cfg_idx_i))
        dmn_pkg::CFG_NODE_ID:    node_id_q    <= cfg_wdata_i[dmn_pkg::NodeIdW-1:0];
        dmn_pkg::CFG_NODE_COUNT: node_count_q <= cfg_wdata_i;
        default:                 node_id_q    <= node_id_q;
      endcase
    end
  end

  assign cfg.node_id = node_id_q;
  assign cfg.want    = peers(node_count_q);

  dmn_front #(
    .ClockBits (ClockBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_hdr_o   (q_hdr),
    .q_stamp_o (q_stamp)
  );

  dmn_back #(
    .ClockBits (ClockBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_hdr_i   (q_hdr),
    .q_stamp_i (q_stamp),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/dmn_front.sv
`default_nettype none

module dmn_front #(
  parameter int unsigned ClockBits = dmn_pkg::ClockBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dmn_in_if.snk                 in_ch,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output dmn_pkg::item_hdr_t    q_hdr_o,
  output logic [ClockBits-1:0]  q_stamp_o
);

  dmn_pkg::item_hdr_t              hdr_q   [dmn_pkg::QueueDepth];
  logic [ClockBits-1:0]            stamp_q [dmn_pkg::QueueDepth];
  logic [dmn_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dmn_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            push;
  dmn_pkg::item_hdr_t              hdr_c;
  logic [ClockBits-1:0]            stamp_c;

  function automatic logic [dmn_pkg::QPtrW-1:0] ptr_inc(logic [dmn_pkg::QPtrW-1:0] p);
    return (p == dmn_pkg::QPtrW'(dmn_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // classify: decode the command, clip the stamp to the clock range
  assign hdr_c.cmd = dmn_pkg::cmd_e'(in_ch.command);
  assign hdr_c.src = in_ch.source;

  if (ClockBits >= dmn_pkg::StampW) begin : g_ext
    assign stamp_c = ClockBits'(in_ch.stamp_in);
  end else begin : g_sat
    assign stamp_c = (|in_ch.stamp_in[dmn_pkg::StampW-1:ClockBits]) ? '1
                                                                      : in_ch.stamp_in[ClockBits-1:0];
  end

  assign in_ch.ready = (cnt_q != dmn_pkg::QCntW'(dmn_pkg::QueueDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign q_hdr_o     = hdr_q[rd_ptr_q];
  assign q_stamp_o   = stamp_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    priority if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hdr_q[wr_ptr_q]   <= hdr_c;
      stamp_q[wr_ptr_q] <= stamp_c;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dmn_back.sv
`default_nettype none

module dmn_back #(
  parameter int unsigned ClockBits = dmn_pkg::ClockBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmn_pkg::cfg_t         cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  dmn_pkg::item_hdr_t    q_hdr_i,
  input  logic [ClockBits-1:0]  q_stamp_i,
  dmn_out_if.src                out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SYNC  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_BCAST = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_REQ  = 3'b010,
    PH_CS   = 3'b100
  } phase_e;

  localparam int unsigned IdW = dmn_pkg::NodeIdW;

  state_e                          state_q, state_d;
  phase_e                          phase_q, phase_d;
  logic [ClockBits-1:0]            clk_q, clk_d, rtime_q, rtime_d, stamp_q, stamp_d;
  logic [IdW-1:0]                  ack_q, ack_d, idx_q, idx_d, sent_q, sent_d;
  logic [dmn_pkg::FifoCntW-1:0]    dcnt_q, dcnt_d;
  logic [IdW-1:0]                  fifo_q [dmn_pkg::FifoDepth];
  logic                            fifo_we;
  dmn_pkg::item_hdr_t              hdr_q, hdr_d;
  logic                            answer_q, answer_d;

  logic                            ov_q, ov_d;
  logic [dmn_pkg::KindW-1:0]       okind_q;
  logic [IdW-1:0]                  odest_q;
  logic [dmn_pkg::StampW-1:0]      ostamp_q;
  logic                            olast_q;

  logic                            out_free, emit, e_last;
  dmn_pkg::kind_e                  e_kind;
  logic [IdW-1:0]                  e_dest;
  logic [ClockBits-1:0]            e_stamp, clk_inc, clk_max;

  function automatic logic [ClockBits-1:0] sat_inc(logic [ClockBits-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign out_free = !ov_q || out_ch.ready;
  assign clk_inc  = sat_inc(clk_q);
  assign clk_max  = (clk_q > stamp_q) ? clk_q : stamp_q;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    clk_d    = clk_q;
    rtime_d  = rtime_q;
    stamp_d  = stamp_q;
    ack_d    = ack_q;
    idx_d    = idx_q;
    sent_d   = sent_q;
    dcnt_d   = dcnt_q;
    hdr_d    = hdr_q;
    answer_d = answer_q;
    fifo_we  = 1'b0;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    e_kind   = dmn_pkg::KIND_ACK;
    e_dest   = '0;
    e_stamp  = clk_q;
    e_last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          hdr_d   = q_hdr_i;
          stamp_d = q_stamp_i;
          state_d = (q_hdr_i.cmd == dmn_pkg::CMD_LREQ || q_hdr_i.cmd == dmn_pkg::CMD_LREL)
                    ? ST_EXEC : ST_SYNC;
        end
      end
      ST_SYNC: begin
        clk_d    = sat_inc(clk_max);
        answer_d = (phase_q == PH_IDLE) ||
                   (phase_q == PH_REQ &&
                    (stamp_q < rtime_q ||
                     (stamp_q == rtime_q && hdr_q.src < cfg_i.node_id)));
        state_d  = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          unique case (hdr_q.cmd)
            dmn_pkg::CMD_LREQ: begin
              if (phase_q == PH_IDLE) begin
                clk_d   = clk_inc;
                rtime_d = clk_inc;
                ack_d   = '0;
                if (cfg_i.want == '0) begin
                  phase_d = PH_CS;
                  emit    = 1'b1;
                  e_kind  = dmn_pkg::KIND_GRANT;
                  e_stamp = clk_inc;
                end else begin
                  phase_d = PH_REQ;
                  idx_d   = '0;
                  sent_d  = '0;
                  state_d = ST_BCAST;
                end
              end
            end
            dmn_pkg::CMD_LREL: begin
              if (phase_q == PH_CS) begin
                phase_d = PH_IDLE;
                if (dcnt_q != '0) begin
                  idx_d   = '0;
                  state_d = ST_DRAIN;
                end
              end
            end
            dmn_pkg::CMD_RREQ: begin
              priority if (answer_q) begin
                clk_d   = clk_inc;
                emit    = 1'b1;
                e_kind  = dmn_pkg::KIND_ACK;
                e_dest  = hdr_q.src;
                e_stamp = clk_inc;
              end else if (dcnt_q < dmn_pkg::FifoCntW'(dmn_pkg::FifoDepth)) begin
                fifo_we = 1'b1;
                dcnt_d  = dcnt_q + 1'b1;
              end else begin
                // drop: deferred queue full
                dcnt_d = dcnt_q;
              end
            end
            dmn_pkg::CMD_RACK: begin
              if (phase_q == PH_REQ) begin
                ack_d = ack_q + 1'b1;
                if (ack_q + 4'd1 == cfg_i.want) begin
                  phase_d = PH_CS;
                  emit    = 1'b1;
                  e_kind  = dmn_pkg::KIND_GRANT;
                end
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_BCAST: begin
        priority if (idx_q == cfg_i.node_id) begin
          idx_d = idx_q + 1'b1;
        end else if (out_free) begin
          emit   = 1'b1;
          e_kind = dmn_pkg::KIND_REQ;
          e_dest = idx_q;
          e_last = (sent_q + 4'd1 == cfg_i.want);
          idx_d  = idx_q + 1'b1;
          sent_d = sent_q + 1'b1;
          if (e_last) begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = dmn_pkg::KIND_ACK;
          e_dest = fifo_q[idx_q[dmn_pkg::FifoPtrW-1:0]];
          e_last = (dmn_pkg::FifoCntW'(idx_q) + 1'b1 == dcnt_q);
          idx_d  = idx_q + 1'b1;
          if (e_last) begin
            dcnt_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    ov_d = emit ? 1'b1 : (out_ch.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_IDLE;
      clk_q    <= '0;
      rtime_q  <= '0;
      ack_q    <= '0;
      dcnt_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      clk_q    <= clk_d;
      rtime_q  <= rtime_d;
      ack_q    <= ack_d;
      dcnt_q   <= dcnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q  <= stamp_d;
    hdr_q    <= hdr_d;
    answer_q <= answer_d;
    idx_q    <= idx_d;
    sent_q   <= sent_d;
    if (fifo_we) begin
      fifo_q[dcnt_q[dmn_pkg::FifoPtrW-1:0]] <= hdr_q.src;
    end
    if (emit) begin
      okind_q  <= e_kind;
      odest_q  <= e_dest;
      ostamp_q <= dmn_pkg::StampW'(e_stamp);
      olast_q  <= e_last;
    end
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.kind      = okind_q;
  assign out_ch.dest      = odest_q;
  assign out_ch.stamp_out = ostamp_q;
  assign out_ch.last      = olast_q;

endmodule

`default_nettype wire

>>> rtl/dmn_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dmn_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [dmn_pkg::KindW-1:0]     out_kind_i,
  input  logic [dmn_pkg::NodeIdW-1:0]   out_dest_i,
  input  logic [dmn_pkg::StampW-1:0]    out_stamp_i,
  input  logic                          out_last_i
);

  `DMN_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> out_valid_i !== 1'b1, "result beat during reset")
  `DMN_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_dest_i) && $stable(out_stamp_i) && $stable(out_last_i), "stalled beat changed")
  `DMN_ASSERT(a_grant_dest, out_valid_i && out_kind_i == dmn_pkg::KIND_GRANT |-> out_dest_i == '0, "grant with nonzero dest")
  `DMN_ASSERT(a_grant_last, out_valid_i && out_kind_i == dmn_pkg::KIND_GRANT |-> out_last_i, "grant not last")

endmodule

bind distributed_mutex_node_core dmn_checker u_dmn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_kind_i  (out_ch.kind),
  .out_dest_i  (out_ch.dest),
  .out_stamp_i (out_ch.stamp_out),
  .out_last_i  (out_ch.last)
);

`default_nettype wire

>>> tb/distributed_mutex_node_core_tb.sv
`timescale 1ns / 100ps

module distributed_mutex_node_core_tb;

  localparam int unsigned QuietCycles = 48;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomBeats = 500;
  localparam int unsigned PrintLimit  = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_CRIT
  } mutex_state_e;

  typedef struct packed {
    dmn_pkg::kind_e                kind;
    logic [dmn_pkg::NodeIdW-1:0]   dest;
    logic [dmn_pkg::StampW-1:0]    stamp;
    logic                          last;
  } msg_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [dmn_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [dmn_pkg::CfgDataW-1:0] cfg_wdata_i;

  dmn_in_if  in_bus ();
  dmn_out_if out_bus ();

  distributed_mutex_node_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_bus),
    .out_ch      (out_bus)
  );

  logic [dmn_pkg::NodeIdW-1:0]  mdl_id;
  logic [dmn_pkg::NodeCntW-1:0] mdl_cnt;
  logic [dmn_pkg::StampW-1:0]   mdl_clock;
  logic [dmn_pkg::StampW-1:0]   mdl_req_time;
  mutex_state_e                 mdl_state;
  logic [3:0]                   mdl_acks;
  logic [dmn_pkg::NodeIdW-1:0]  mdl_deferred[$];

  msg_t expected_msgs[$];

  int err_count   = 0;
  int burst_left  = 0;
  int beats_sent  = 0;
  int idle_cycles = 0;
  int rdy_left    = 0;
  int rdy_mode    = 0;
  int rdy_tick    = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic [dmn_pkg::StampW-1:0] bump(input logic [dmn_pkg::StampW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int unsigned active_nodes();
    int unsigned n;
    n = mdl_cnt;
    if (n < 1) n = 1;
    if (n > dmn_pkg::NodeLim) n = dmn_pkg::NodeLim;
    return n;
  endfunction

  task automatic predict_node(input dmn_pkg::cmd_e c, input logic [dmn_pkg::NodeIdW-1:0] s,
                              input logic [dmn_pkg::StampW-1:0] st);
    msg_t        outs[$];
    msg_t        m;
    int unsigned n;
    int unsigned want;
    int unsigned sent;
    logic        answer;
    n = active_nodes();
    case (c)
      dmn_pkg::CMD_LREQ: begin
        if (mdl_state == ST_IDLE) begin
          want = n - 1;
          sent = 0;
          mdl_clock    = bump(mdl_clock);
          mdl_req_time = mdl_clock;
          mdl_acks     = '0;
          mdl_state    = ST_WAIT;
          for (int j = 0; j < 16; j++) begin
            if (sent < want && j != mdl_id) begin
              outs.push_back(msg_t'{dmn_pkg::KIND_REQ, j[dmn_pkg::NodeIdW-1:0], mdl_clock,
                                    1'b0});
              sent++;
            end
          end
          if (want == 0) begin
            mdl_state = ST_CRIT;
            outs.push_back(msg_t'{dmn_pkg::KIND_GRANT, '0, mdl_clock, 1'b0});
          end
        end
      end
      dmn_pkg::CMD_LREL: begin
        if (mdl_state == ST_CRIT) begin
          foreach (mdl_deferred[i])
            outs.push_back(msg_t'{dmn_pkg::KIND_ACK, mdl_deferred[i], mdl_clock, 1'b0});
          mdl_deferred.delete();
          mdl_state = ST_IDLE;
        end
      end
      default: begin
        mdl_clock = bump((mdl_clock > st) ? mdl_clock : st);
        if (c == dmn_pkg::CMD_RREQ) begin
          answer = (mdl_state == ST_IDLE) ||
                   (mdl_state == ST_WAIT &&
                    (st < mdl_req_time || (st == mdl_req_time && s < mdl_id)));
          if (answer) begin
            mdl_clock = bump(mdl_clock);
            outs.push_back(msg_t'{dmn_pkg::KIND_ACK, s, mdl_clock, 1'b0});
          end else if (mdl_deferred.size() < dmn_pkg::FifoDepth) begin
            mdl_deferred.push_back(s);
          end
        end else if (mdl_state == ST_WAIT) begin
          mdl_acks = mdl_acks + 1'b1;
          if (mdl_acks == n - 1) begin
            mdl_state = ST_CRIT;
            outs.push_back(msg_t'{dmn_pkg::KIND_GRANT, '0, mdl_clock, 1'b0});
          end
        end
      end
    endcase
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_msgs.push_back(outs[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [dmn_pkg::StampW-1:0] got,
                                 input logic [dmn_pkg::StampW-1:0] want);
    err_count++;
    if (err_count <= PrintLimit)
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_beat(input dmn_pkg::cmd_e c, input logic [dmn_pkg::NodeIdW-1:0] s,
                           input logic [dmn_pkg::StampW-1:0] st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid    <= 1'b1;
    in_bus.command  <= c;
    in_bus.source   <= s;
    in_bus.stamp_in <= st;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_node(c, s, st);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_msgs.size() != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input dmn_pkg::cfg_idx_e idx,
                           input logic [dmn_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == dmn_pkg::CFG_NODE_ID) mdl_id = val[dmn_pkg::NodeIdW-1:0];
    else mdl_cnt = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [dmn_pkg::StampW-1:0] rand_stamp();
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return $urandom;
    if (r < 4) return $urandom_range(0, 15);
    if (mdl_clock < 3) return $urandom_range(0, 6);
    return mdl_clock + $urandom_range(0, 6) - 3;
  endfunction

  function automatic logic [dmn_pkg::StampW-1:0] rival_stamp();
    case ($urandom_range(0, 3))
      0: return (mdl_req_time > 0) ? mdl_req_time - 1 : mdl_req_time;
      1: return mdl_req_time;
      2: return mdl_req_time + 1;
      default: return rand_stamp();
    endcase
  endfunction

  task automatic test_lone_node();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd1);
    send_beat(dmn_pkg::CMD_LREQ, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_LREL, 4'd15, 32'hFFFF_FFFF);
    wait_quiet();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd0);
    send_beat(dmn_pkg::CMD_LREQ, 4'd15, 32'hFFFF_FFFF);
    send_beat(dmn_pkg::CMD_LREL, 4'd0, 32'h0);
    wait_quiet();
  endtask

  task automatic test_priority();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd16);
    write_reg(dmn_pkg::CFG_NODE_ID, 5'd7);
    send_beat(dmn_pkg::CMD_LREQ, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_RREQ, 4'd3, mdl_req_time);
    send_beat(dmn_pkg::CMD_RREQ, 4'd9, mdl_req_time);
    send_beat(dmn_pkg::CMD_RREQ, 4'd0, mdl_req_time - 1);
    wait_quiet();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd2);
    send_beat(dmn_pkg::CMD_RACK, 4'd1, 32'h0);
    send_beat(dmn_pkg::CMD_RREQ, 4'd14, 32'h0);
    send_beat(dmn_pkg::CMD_LREQ, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_LREL, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_LREL, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_RACK, 4'd2, mdl_clock);
    send_beat(dmn_pkg::CMD_RREQ, 4'd15, 32'h0);
    wait_quiet();
  endtask

  task automatic test_sparse_ids();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd3);
    write_reg(dmn_pkg::CFG_NODE_ID, 5'd12);
    send_beat(dmn_pkg::CMD_LREQ, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_RACK, 4'd0, mdl_clock);
    send_beat(dmn_pkg::CMD_RACK, 4'd1, mdl_clock);
    send_beat(dmn_pkg::CMD_LREL, 4'd0, 32'h0);
    wait_quiet();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd31);
    write_reg(dmn_pkg::CFG_NODE_ID, 5'd16);
    send_beat(dmn_pkg::CMD_LREQ, 4'd0, 32'h0);
    wait_quiet();
    write_reg(dmn_pkg::CFG_NODE_COUNT, 5'd2);
    send_beat(dmn_pkg::CMD_RACK, 4'd5, mdl_clock);
    send_beat(dmn_pkg::CMD_LREL, 4'd0, 32'h0);
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    int          start;
    int unsigned acks_left;
    int unsigned reqs_left;
    logic        broken;
    logic        flood;
    logic [dmn_pkg::CfgDataW-1:0] cnt_val;
    start = beats_sent;
    while (beats_sent - start < RandomBeats) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_quiet();
        case ($urandom_range(0, 9))
          0: cnt_val = 5'd0;
          1: cnt_val = 5'd16;
          2: cnt_val = 5'd17;
          3: cnt_val = 5'd31;
          default: cnt_val = $urandom_range(1, 5);
        endcase
        write_reg(dmn_pkg::CFG_NODE_COUNT, cnt_val);
        write_reg(dmn_pkg::CFG_NODE_ID, {1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))});
      end
      send_beat(dmn_pkg::CMD_LREQ, 4'($urandom_range(0, 15)), $urandom);
      broken    = ($urandom_range(0, 9) == 0);
      flood     = ($urandom_range(0, 7) == 0);
      acks_left = active_nodes() - 1;
      if (broken) acks_left = $urandom_range(0, acks_left);
      reqs_left = flood ? $urandom_range(15, 18) : $urandom_range(0, 3);
      while (acks_left > 0 || reqs_left > 0) begin
        if (reqs_left > 0 && (acks_left == 0 || $urandom_range(0, 1) == 1)) begin
          send_beat(dmn_pkg::CMD_RREQ, 4'($urandom_range(0, 15)),
                    flood ? mdl_req_time + $urandom_range(1, 4) : rival_stamp());
          reqs_left--;
        end else begin
          send_beat(dmn_pkg::CMD_RACK, 4'($urandom_range(0, 15)), rand_stamp());
          acks_left--;
        end
      end
      if ($urandom_range(0, 3) == 0)
        send_beat(dmn_pkg::cmd_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  rand_stamp());
      if (!broken || $urandom_range(0, 1) == 1)
        send_beat(dmn_pkg::CMD_LREL, 4'($urandom_range(0, 15)), $urandom);
    end
    wait_quiet();
  endtask

  task automatic test_clock_saturation();
    send_beat(dmn_pkg::CMD_RREQ, 4'd5, 32'hFFFF_FFFF);
    send_beat(dmn_pkg::CMD_RREQ, 4'd10, 32'hFFFF_FFFE);
    send_beat(dmn_pkg::CMD_LREQ, 4'd0, 32'h0);
    send_beat(dmn_pkg::CMD_RACK, 4'd3, 32'h0);
  endtask

  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(16, 128);
    end
    rdy_left--;
    rdy_tick++;
    case (rdy_mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 3) != 0);
      2: out_bus.ready <= (rdy_tick % 3 != 0);
      default: out_bus.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    msg_t want;
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_msgs.size() == 0) begin
          report_mismatch("unexpected beat, kind", out_bus.kind, '0);
        end else begin
          want = expected_msgs.pop_front();
          if (out_bus.kind != want.kind) report_mismatch("kind", out_bus.kind, want.kind);
          if (out_bus.dest != want.dest) report_mismatch("dest", out_bus.dest, want.dest);
          if (out_bus.stamp_out != want.stamp)
            report_mismatch("stamp_out", out_bus.stamp_out, want.stamp);
          if (out_bus.last != want.last) report_mismatch("last", out_bus.last, want.last);
        end
      end
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = dmn_pkg::CFG_NODE_ID;
    cfg_wdata_i     = '0;
    in_bus.valid    = 1'b0;
    in_bus.command  = dmn_pkg::CMD_LREQ;
    in_bus.source   = '0;
    in_bus.stamp_in = '0;
    out_bus.ready   = 1'b0;
    mdl_id          = '0;
    mdl_cnt         = 5'd2;
    mdl_clock       = '0;
    mdl_req_time    = '0;
    mdl_state       = ST_IDLE;
    mdl_acks        = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_lone_node();
    test_priority();
    test_sparse_ids();
    test_random_traffic();
    test_clock_saturation();
    wait_quiet();
    if (expected_msgs.size() != 0)
      report_mismatch("outstanding beats", '0, expected_msgs.size());
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/dmn_pkg.sv
rtl/dmn_ifs.sv
rtl/dmn_front.sv
rtl/dmn_back.sv
rtl/distributed_mutex_node_core.sv
rtl/dmn_checker.sv
tb/distributed_mutex_node_core_tb.sv
